>>> rtl/core/rfr_pkg.sv
// rfr_pkg: shared types and constants of the radar serial frame receiver
// used by rfr_ctrl, rfr_dp and the top level; no dependencies
package rfr_pkg;

	// framing
	localparam logic [7:0] HDR_BYTE  = 8'h55;
	localparam int         LEN_W     = 9;
	localparam logic [LEN_W-1:0] LEN_MAX = 9'h1FF;
	localparam int         NEW_W     = 17;
	localparam int         DEC_BYTES = 10;
	localparam int         RUN_W     = 3;
	localparam logic [RUN_W-1:0] OVR_LIMIT = 3'd5;

	// address bytes
	localparam logic [7:0] ADDR_SYS    = 8'h01;
	localparam logic [7:0] ADDR_REPORT = 8'h03;
	localparam logic [7:0] ADDR_SET    = 8'h04;
	localparam logic [7:0] SUB_ID      = 8'h01;
	localparam logic [7:0] SUB_SW_VER  = 8'h02;
	localparam logic [7:0] SUB_HW_VER  = 8'h03;
	localparam logic [7:0] SUB_PRES    = 8'h05;
	localparam logic [7:0] SUB_MOVE    = 8'h06;
	localparam logic [7:0] SUB_GEAR    = 8'h0C;
	localparam logic [7:0] SUB_SCENE   = 8'h10;
	localparam logic [7:0] FLAG_ON     = 8'h01;

	// event kinds
	localparam logic [3:0] KIND_PRES     = 4'd0;
	localparam logic [3:0] KIND_MOVE     = 4'd1;
	localparam logic [3:0] KIND_ID       = 4'd2;
	localparam logic [3:0] KIND_SW_VER   = 4'd3;
	localparam logic [3:0] KIND_HW_VER   = 4'd4;
	localparam logic [3:0] KIND_GEAR     = 4'd5;
	localparam logic [3:0] KIND_SCENE    = 4'd6;
	localparam logic [3:0] KIND_INVALID  = 4'd7;
	localparam logic [3:0] KIND_UNHANDLD = 4'd8;
	localparam logic [3:0] KIND_OVERRUN  = 4'd9;
	localparam logic [3:0] KIND_TOO_LONG = 4'd10;
	localparam logic [3:0] KIND_SCN_RNG  = 4'd11;

	// movement classes and float thresholds
	localparam logic [2:0] CLS_UNOCC   = 3'd0;
	localparam logic [2:0] CLS_REST    = 3'd1;
	localparam logic [2:0] CLS_MICRO   = 3'd2;
	localparam logic [2:0] CLS_WALK    = 3'd3;
	localparam logic [2:0] CLS_RUN     = 3'd4;
	localparam logic [31:0] F_INF      = 32'h7F800000;
	localparam logic [31:0] F_ONE      = 32'h3F800000;
	localparam logic [31:0] F_TWO      = 32'h40000000;
	localparam logic [31:0] F_THIRTY   = 32'h41F00000;
	localparam logic [31:0] F_SIXTY    = 32'h42700000;

	// controller to datapath
	typedef struct packed {
		logic store;
		logic fetch_len;
		logic fetch_dec;
		logic set_len;
		logic too_long;
		logic decode;
		logic ovf_start;
		logic resync;
		logic emit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic drop;
		logic fill_is3;
		logic len_big;
		logic complete;
		logic over;
		logic walk_done;
		logic res_pend;
		logic out_free;
	} dp_status_t;

	// one result item
	typedef struct packed {
		logic [3:0]       event_kind;
		logic             presence;
		logic             motion;
		logic [31:0]      movement_bits;
		logic [2:0]       movement_class;
		logic [7:0]       gear;
		logic [7:0]       scene_mode;
		logic [7:0]       frame_function;
		logic [7:0]       frame_addr_high;
		logic [7:0]       frame_addr_low;
		logic [LEN_W-1:0] frame_length;
	} res_t;

endpackage

>>> rtl/core/rfr_ram.sv
// rfr_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module rfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 129
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/core/rfr_dp.sv
// rfr_dp: byte store, fill and length state, memory walker, frame decode, result regs
// depends on rfr_pkg and rfr_ram
module rfr_dp import rfr_pkg::*; #(
	parameter int STORE_LIMIT = 128,
	parameter int MAX_FRAME   = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_cmd_t  cmd,
	output dp_status_t st,
	input  logic [7:0] rx_byte,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       out_ready,
	output logic       out_valid,
	output res_t       out_res
);

	localparam int DEPTH = STORE_LIMIT + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int FW    = $clog2(STORE_LIMIT + 2);
	localparam int EW    = $clog2(MAX_FRAME + 1);
	localparam int CW    = (FW > EW) ? FW : EW;

	typedef enum logic [1:0] {M_NONE, M_FETCH, M_SCAN, M_SHIFT} walk_mode_t;

	logic [FW-1:0]    fill_q, idx_q, end_q, base_q, pidx_q, found_q;
	logic [EW-1:0]    exp_q;
	logic [RUN_W-1:0] run_q, run_nx;
	logic [7:0]       scene_count_q;
	walk_mode_t       mode_q;
	logic             pend_q, hit_q, res_pend_q, out_valid_q;
	logic [7:0]       hb_q [DEC_BYTES];
	res_t             res_q, out_q, dec_res;
	logic [CW-1:0]    fill_x, exp_x;
	logic [FW:0]      src_sum;
	logic [NEW_W-1:0] new_exp;
	logic             issue, walk_done;
	logic             wr_en;
	logic [AW-1:0]    wr_addr, rd_addr;
	logic [7:0]       wr_data, rd_data;
	logic [31:0]      mv_bits;

	// store memory
	rfr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// comparisons
	assign fill_x  = CW'(fill_q);
	assign exp_x   = CW'(exp_q);
	assign new_exp = {1'b0, hb_q[2], hb_q[1]} + NEW_W'(1);
	assign run_nx  = run_q + RUN_W'(1);

	// status to controller
	always_comb begin
		st.drop      = (fill_q == '0) && (rx_byte != HDR_BYTE);
		st.fill_is3  = fill_q == FW'(3);
		st.len_big   = new_exp > NEW_W'(MAX_FRAME);
		st.complete  = (exp_q != '0) && (fill_x >= exp_x);
		st.over      = fill_q > FW'(STORE_LIMIT);
		st.walk_done = walk_done;
		st.res_pend  = res_pend_q;
		st.out_free  = !out_valid_q || out_ready;
	end

	// walker: sequential reads for fetch, header scan and store shift
	assign issue     = (mode_q != M_NONE) && (idx_q < end_q) && !((mode_q == M_SCAN) && hit_q);
	assign walk_done = (mode_q != M_NONE) && !issue && !pend_q;
	assign src_sum   = {1'b0, base_q} + {1'b0, idx_q};
	assign rd_addr   = (mode_q == M_SHIFT) ? src_sum[AW-1:0] : idx_q[AW-1:0];

	// write port: new byte or shifted byte
	assign wr_en   = cmd.store || (pend_q && (mode_q == M_SHIFT));
	assign wr_addr = cmd.store ? fill_q[AW-1:0] : pidx_q[AW-1:0];
	assign wr_data = cmd.store ? rx_byte : rd_data;

	// movement class on ieee bit patterns
	function automatic logic [2:0] move_class(input logic [31:0] b);
		logic [2:0] c;
		if ({1'b0, b[30:0]} > F_INF) c = CLS_RUN;
		else if (b[31])              c = CLS_UNOCC;
		else if (b < F_ONE)          c = CLS_UNOCC;
		else if (b < F_TWO)          c = CLS_REST;
		else if (b <= F_THIRTY)      c = CLS_MICRO;
		else if (b <= F_SIXTY)       c = CLS_WALK;
		else                         c = CLS_RUN;
		return c;
	endfunction

	assign mv_bits = {hb_q[9], hb_q[8], hb_q[7], hb_q[6]};

	// frame decode from the fetched head bytes
	always_comb begin
		dec_res = '0;
		dec_res.frame_length = LEN_W'(exp_q);
		if (exp_q < EW'(7) || hb_q[0] != HDR_BYTE) begin
			dec_res.event_kind = KIND_INVALID;
		end else begin
			dec_res.frame_function  = hb_q[3];
			dec_res.frame_addr_high = hb_q[4];
			dec_res.frame_addr_low  = hb_q[5];
			if (hb_q[4] == ADDR_REPORT && hb_q[5] == SUB_PRES && exp_q >= EW'(10)) begin
				dec_res.event_kind = KIND_PRES;
				dec_res.presence   = hb_q[6] == FLAG_ON;
				dec_res.motion     = hb_q[7] == FLAG_ON;
			end else if (hb_q[4] == ADDR_REPORT && hb_q[5] == SUB_MOVE &&
					exp_q >= EW'(11)) begin
				dec_res.event_kind     = KIND_MOVE;
				dec_res.movement_bits  = mv_bits;
				dec_res.movement_class = move_class(mv_bits);
			end else if (hb_q[4] == ADDR_SYS && hb_q[5] == SUB_ID && exp_q >= EW'(19)) begin
				dec_res.event_kind = KIND_ID;
			end else if (hb_q[4] == ADDR_SYS && hb_q[5] == SUB_SW_VER &&
					exp_q >= EW'(22)) begin
				dec_res.event_kind = KIND_SW_VER;
			end else if (hb_q[4] == ADDR_SYS && hb_q[5] == SUB_HW_VER &&
					exp_q >= EW'(8)) begin
				dec_res.event_kind = KIND_HW_VER;
			end else if (hb_q[4] == ADDR_SET && hb_q[5] == SUB_GEAR && exp_q >= EW'(8)) begin
				dec_res.event_kind = KIND_GEAR;
				dec_res.gear       = hb_q[6];
			end else if (hb_q[4] == ADDR_SET && hb_q[5] == SUB_SCENE &&
					exp_q >= EW'(8)) begin
				dec_res.scene_mode = hb_q[6];
				dec_res.event_kind = (hb_q[6] < scene_count_q) ? KIND_SCENE : KIND_SCN_RNG;
			end else begin
				dec_res.event_kind = KIND_UNHANDLD;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q        <= '0;
			exp_q         <= '0;
			run_q         <= '0;
			scene_count_q <= '0;
			mode_q        <= M_NONE;
			idx_q         <= '0;
			end_q         <= '0;
			base_q        <= '0;
			pend_q        <= 1'b0;
			pidx_q        <= '0;
			hit_q         <= 1'b0;
			found_q       <= '0;
			res_pend_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				scene_count_q <= cfg_wr_data;
			end
			if (cmd.store) begin
				fill_q <= fill_q + FW'(1);
			end
			// walker step
			if (mode_q != M_NONE) begin
				if (issue) begin
					idx_q <= idx_q + FW'(1);
				end
				pend_q <= issue;
				pidx_q <= idx_q;
				if (pend_q && mode_q == M_SCAN && !hit_q && rd_data == HDR_BYTE) begin
					hit_q   <= 1'b1;
					found_q <= pidx_q;
				end
				if (walk_done) begin
					mode_q <= M_NONE;
				end
			end else begin
				pend_q <= 1'b0;
			end
			// walker starts and state updates
			if (cmd.fetch_len) begin
				mode_q <= M_FETCH;
				idx_q  <= FW'(1);
				end_q  <= FW'(3);
			end
			if (cmd.fetch_dec) begin
				mode_q <= M_FETCH;
				idx_q  <= '0;
				end_q  <= FW'(DEC_BYTES);
			end
			if (cmd.set_len) begin
				exp_q <= new_exp[EW-1:0];
			end
			if (cmd.too_long) begin
				fill_q     <= '0;
				exp_q      <= '0;
				res_pend_q <= 1'b1;
			end
			if (cmd.decode) begin
				mode_q     <= M_SHIFT;
				base_q     <= FW'(exp_q);
				idx_q      <= '0;
				end_q      <= FW'(fill_x - exp_x);
				fill_q     <= FW'(fill_x - exp_x);
				exp_q      <= '0;
				run_q      <= '0;
				res_pend_q <= 1'b1;
			end
			if (cmd.ovf_start) begin
				mode_q     <= M_SCAN;
				idx_q      <= FW'(1);
				end_q      <= fill_q;
				hit_q      <= 1'b0;
				res_pend_q <= 1'b1;
			end
			if (cmd.resync) begin
				mode_q <= M_SHIFT;
				idx_q  <= '0;
				exp_q  <= '0;
				if (run_nx >= OVR_LIMIT) begin
					run_q  <= '0;
					fill_q <= '0;
					end_q  <= '0;
				end else if (hit_q) begin
					run_q  <= run_nx;
					base_q <= found_q;
					end_q  <= fill_q - found_q;
					fill_q <= fill_q - found_q;
				end else begin
					run_q  <= run_nx;
					fill_q <= '0;
					end_q  <= '0;
				end
			end
			// output register handshake
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				res_pend_q  <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pend_q && mode_q == M_FETCH) begin
			hb_q[pidx_q[$clog2(DEC_BYTES)-1:0]] <= rd_data;
		end
		if (cmd.decode) begin
			res_q <= dec_res;
		end else if (cmd.too_long) begin
			res_q              <= '0;
			res_q.event_kind   <= KIND_TOO_LONG;
			res_q.frame_length <= (new_exp > NEW_W'(LEN_MAX)) ? LEN_MAX : new_exp[LEN_W-1:0];
		end else if (cmd.ovf_start) begin
			res_q              <= '0;
			res_q.event_kind   <= KIND_OVERRUN;
			res_q.frame_length <= LEN_W'(fill_q);
		end
		if (cmd.emit) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(STORE_LIMIT + 1))
		else $error("store fill beyond capacity");
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_q < OVR_LIMIT)
		else $error("overrun run not cleared");
	a_emit_pend: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> res_pend_q && (!out_valid_q || out_ready))
		else $error("emit without a pending result or free output");
	a_shift_dst: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && mode_q == M_SHIFT) |-> pidx_q < fill_q)
		else $error("shift writes past the fill");
	a_exp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(exp_q != '0) |-> exp_x <= CW'(MAX_FRAME))
		else $error("expected size above frame limit");

endmodule

>>> rtl/core/rfr_ctrl.sv
// rfr_ctrl: sequencing state machine of the frame receiver
// depends on rfr_pkg
module rfr_ctrl import rfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t st,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_AFTER, S_LEN_WAIT, S_LEN_SET, S_CMPL, S_DEC_WAIT, S_DEC_SET,
		S_DSHIFT, S_OVF, S_SCAN_WAIT, S_RESYNC, S_RSHIFT, S_EMIT
	} state_t;

	state_t state_q, state_nx;

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && !st.drop) begin
					cmd.store = 1'b1;
					state_nx  = S_AFTER;
				end
			end
			S_AFTER: begin
				if (st.fill_is3) begin
					cmd.fetch_len = 1'b1;
					state_nx      = S_LEN_WAIT;
				end else begin
					state_nx = S_CMPL;
				end
			end
			S_LEN_WAIT: begin
				if (st.walk_done) state_nx = S_LEN_SET;
			end
			S_LEN_SET: begin
				if (st.len_big) begin
					cmd.too_long = 1'b1;
					state_nx     = S_EMIT;
				end else begin
					cmd.set_len = 1'b1;
					state_nx    = S_CMPL;
				end
			end
			S_CMPL: begin
				if (st.complete) begin
					cmd.fetch_dec = 1'b1;
					state_nx      = S_DEC_WAIT;
				end else begin
					state_nx = S_OVF;
				end
			end
			S_DEC_WAIT: begin
				if (st.walk_done) state_nx = S_DEC_SET;
			end
			S_DEC_SET: begin
				cmd.decode = 1'b1;
				state_nx   = S_DSHIFT;
			end
			S_DSHIFT: begin
				if (st.walk_done) state_nx = S_OVF;
			end
			S_OVF: begin
				if (st.over) begin
					cmd.ovf_start = 1'b1;
					state_nx      = S_SCAN_WAIT;
				end else begin
					state_nx = S_EMIT;
				end
			end
			S_SCAN_WAIT: begin
				if (st.walk_done) state_nx = S_RESYNC;
			end
			S_RESYNC: begin
				cmd.resync = 1'b1;
				state_nx   = S_RSHIFT;
			end
			S_RSHIFT: begin
				if (st.walk_done) state_nx = S_EMIT;
			end
			S_EMIT: begin
				if (!st.res_pend) begin
					state_nx = S_IDLE;
				end else if (st.out_free) begin
					cmd.emit = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

>>> rtl/core/radar_uart_frame_receiver_unit.sv
// radar_uart_frame_receiver_unit: top level of the radar serial frame receiver
// depends on rfr_pkg, rfr_ctrl, rfr_dp (and rfr_ram through rfr_dp)
//
// Usage:
//   Input channel in_valid/in_ready carries one received byte (rx_byte) per item.
//   Output channel out_valid/out_ready carries one event per item; a byte gives
//   zero or one event. scene_count is written through cfg_wr_en/cfg_wr_data
//   while the block is idle.
//   One item at a time: in_ready is high only while the controller is idle.
//   Work per byte: an idle-line byte is dropped; the third byte adds the 2-byte
//   length fetch; a completed frame adds the 10-byte head fetch and decode, plus
//   a shift of the leftover bytes; an overrun adds a header scan and a shift of
//   the kept bytes. All of these go through the single read port of the byte
//   store memory.
//   A finished event waits in the output register; the next byte is accepted
//   meanwhile, and the block stalls only when a new event meets a full output.
//   Reset empties the store, clears length and overrun state and scene_count.
module radar_uart_frame_receiver_unit import rfr_pkg::*; #(
	parameter int STORE_LIMIT = 128,
	parameter int MAX_FRAME   = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       rx_byte,
	input  logic             cfg_wr_en,
	input  logic [7:0]       cfg_wr_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [3:0]       event_kind,
	output logic             presence,
	output logic             motion,
	output logic [31:0]      movement_bits,
	output logic [2:0]       movement_class,
	output logic [7:0]       gear,
	output logic [7:0]       scene_mode,
	output logic [7:0]       frame_function,
	output logic [7:0]       frame_addr_high,
	output logic [7:0]       frame_addr_low,
	output logic [LEN_W-1:0] frame_length
);

	ctrl_cmd_t  cmd;
	dp_status_t st;
	res_t       res;

	rfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	rfr_dp #(.STORE_LIMIT(STORE_LIMIT), .MAX_FRAME(MAX_FRAME)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.rx_byte     (rx_byte),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.out_res     (res)
	);

	// result fields onto ports
	assign event_kind      = res.event_kind;
	assign presence        = res.presence;
	assign motion          = res.motion;
	assign movement_bits   = res.movement_bits;
	assign movement_class  = res.movement_class;
	assign gear            = res.gear;
	assign scene_mode      = res.scene_mode;
	assign frame_function  = res.frame_function;
	assign frame_addr_high = res.frame_addr_high;
	assign frame_addr_low  = res.frame_addr_low;
	assign frame_length    = res.frame_length;

endmodule

>>> sim/radar_uart_frame_receiver_unit_test.sv
// radar_uart_frame_receiver_unit_test: self-checking bench for the radar serial frame receiver
// drives received bytes with random gaps, tracks frames in its own model, checks every event
// depends on rfr_pkg and radar_uart_frame_receiver_unit
`timescale 1ns / 100ps

module radar_uart_frame_receiver_unit_test;
	import rfr_pkg::*;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [7:0]       rx_byte = 8'h00;
	logic             cfg_wr_en = 1'b0;
	logic [7:0]       cfg_wr_data = 8'h00;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [3:0]       event_kind;
	logic             presence;
	logic             motion;
	logic [31:0]      movement_bits;
	logic [2:0]       movement_class;
	logic [7:0]       gear;
	logic [7:0]       scene_mode;
	logic [7:0]       frame_function;
	logic [7:0]       frame_addr_high;
	logic [7:0]       frame_addr_low;
	logic [LEN_W-1:0] frame_length;

	radar_uart_frame_receiver_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.event_kind(event_kind), .presence(presence), .motion(motion),
		.movement_bits(movement_bits), .movement_class(movement_class),
		.gear(gear), .scene_mode(scene_mode), .frame_function(frame_function),
		.frame_addr_high(frame_addr_high), .frame_addr_low(frame_addr_low),
		.frame_length(frame_length)
	);

	// receiver state as tracked by the bench
	logic [7:0] frame_bytes [0:128];
	int         frame_fill = 0;
	int         frame_size = 0;
	int         overrun_count = 0;
	logic [7:0] scene_limit = 8'd0;
	res_t       expected_events [$];

	int  mismatches = 0;
	int  bytes_sent = 0;
	int  out_hold = 0;
	bit  calm = 1'b0;

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	// watchdog
	initial begin
		#4000000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 6);
	endfunction

	function automatic logic [2:0] classify_movement(input logic [31:0] b);
		if ((b & 32'h7FFFFFFF) > F_INF) return CLS_RUN;
		if (b[31]) return CLS_UNOCC;
		if (b < F_ONE) return CLS_UNOCC;
		if (b < F_TWO) return CLS_REST;
		if (b <= F_THIRTY) return CLS_MICRO;
		if (b <= F_SIXTY) return CLS_WALK;
		return CLS_RUN;
	endfunction

	// decode of the frame at the front of the tracked store
	function automatic res_t decode_frame(input int len);
		res_t ev;
		logic [7:0] a1, a2;
		logic [31:0] mv;
		ev = '0;
		ev.frame_length = len[LEN_W-1:0];
		if (len < 7 || frame_bytes[0] != HDR_BYTE) begin
			ev.event_kind = KIND_INVALID;
			return ev;
		end
		a1 = frame_bytes[4];
		a2 = frame_bytes[5];
		ev.frame_function  = frame_bytes[3];
		ev.frame_addr_high = a1;
		ev.frame_addr_low  = a2;
		if (a1 == ADDR_REPORT && a2 == SUB_PRES && len >= 10) begin
			ev.event_kind = KIND_PRES;
			ev.presence = (frame_bytes[6] == FLAG_ON);
			ev.motion   = (frame_bytes[7] == FLAG_ON);
		end else if (a1 == ADDR_REPORT && a2 == SUB_MOVE && len >= 11) begin
			mv = {frame_bytes[9], frame_bytes[8], frame_bytes[7], frame_bytes[6]};
			ev.event_kind = KIND_MOVE;
			ev.movement_bits = mv;
			ev.movement_class = classify_movement(mv);
		end else if (a1 == ADDR_SYS && a2 == SUB_ID && len >= 19) begin
			ev.event_kind = KIND_ID;
		end else if (a1 == ADDR_SYS && a2 == SUB_SW_VER && len >= 22) begin
			ev.event_kind = KIND_SW_VER;
		end else if (a1 == ADDR_SYS && a2 == SUB_HW_VER && len >= 8) begin
			ev.event_kind = KIND_HW_VER;
		end else if (a1 == ADDR_SET && a2 == SUB_GEAR && len >= 8) begin
			ev.event_kind = KIND_GEAR;
			ev.gear = frame_bytes[6];
		end else if (a1 == ADDR_SET && a2 == SUB_SCENE && len >= 8) begin
			ev.scene_mode = frame_bytes[6];
			ev.event_kind = (frame_bytes[6] < scene_limit) ? KIND_SCENE : KIND_SCN_RNG;
		end else begin
			ev.event_kind = KIND_UNHANDLD;
		end
		return ev;
	endfunction

	// update tracked state for one accepted byte and queue the event it causes
	task automatic track_rx_byte(input logic [7:0] b);
		res_t ev;
		bit   hit;
		int   k, n, len;
		ev = '0;
		hit = 1'b0;
		if (frame_fill == 0 && b != HDR_BYTE) return;
		frame_bytes[frame_fill] = b;
		frame_fill++;
		if (frame_fill == 3) begin
			frame_size = int'(frame_bytes[1]) + (int'(frame_bytes[2]) << 8) + 1;
			if (frame_size > 256) begin
				ev.event_kind = KIND_TOO_LONG;
				ev.frame_length = (frame_size > 511) ? LEN_MAX : frame_size[LEN_W-1:0];
				frame_fill = 0;
				frame_size = 0;
				expected_events.insert(expected_events.size(), ev);
				return;
			end
		end
		// complete frame: decode then shift leftovers down
		if (frame_size > 0 && frame_fill >= frame_size) begin
			len = frame_size;
			ev = decode_frame(len);
			hit = 1'b1;
			n = frame_fill - len;
			for (k = 0; k < n; k++) frame_bytes[k] = frame_bytes[k + len];
			frame_fill = n;
			frame_size = 0;
			overrun_count = 0;
		end
		// overrun: resync to next header byte
		if (frame_fill > 128) begin
			ev.event_kind = KIND_OVERRUN;
			ev.frame_length = frame_fill[LEN_W-1:0];
			hit = 1'b1;
			k = 1;
			while (k < frame_fill && frame_bytes[k] != HDR_BYTE) k++;
			if (k < frame_fill) begin
				n = frame_fill - k;
				for (len = 0; len < n; len++) frame_bytes[len] = frame_bytes[len + k];
				frame_fill = n;
			end else begin
				frame_fill = 0;
			end
			frame_size = 0;
			overrun_count++;
			if (overrun_count >= 5) begin
				frame_fill = 0;
				overrun_count = 0;
			end
		end
		if (hit) expected_events.insert(expected_events.size(), ev);
	endtask

	// send one item on the input channel
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		track_rx_byte(b);
		bytes_sent++;
	endtask

	// wait for every expected event, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_events.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_scene_count(input logic [7:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		scene_limit = v;
		@(posedge clk);
	endtask

	// frame of a given total size (head bytes only above 256); bytes 6..9 taken from pay
	task automatic send_frame(input logic [7:0] a1, input logic [7:0] a2, input int size,
			input logic [31:0] pay);
		int i;
		logic [15:0] lf;
		logic [7:0] bt;
		lf = 16'(size - 1);
		send_byte(HDR_BYTE);
		send_byte(lf[7:0]);
		send_byte(lf[15:8]);
		if (size > 256) return;
		for (i = 3; i < size; i++) begin
			if (i == 4) bt = a1;
			else if (i == 5) bt = a2;
			else if (i >= 6 && i <= 9) bt = 8'(pay >> (8 * (i - 6)));
			else bt = 8'($urandom);
			send_byte(bt);
		end
	endtask

	// event checker and receiver stall
	always @(posedge clk) begin : event_check
		res_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{event_kind, presence, motion, movement_bits, movement_class, gear,
				scene_mode, frame_function, frame_addr_high, frame_addr_low, frame_length};
			if (expected_events.size() == 0) begin
				if (mismatches < 10) $display("unexpected event %h", got);
				mismatches++;
			end else begin
				want = expected_events.pop_front();
				if (got !== want) begin
					if (mismatches < 10) $display("event mismatch: expected %h actual %h", want, got);
					mismatches++;
				end
			end
			out_hold = draw_gap();
		end
		if (out_hold > 0) begin
			out_ready <= 1'b0;
			out_hold--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// idle line bytes, tiny lengths, invalid and oversized frames
	task automatic test_framing_limits();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(8'h00, 8'h00, 1, 32'h0);
		send_frame(8'h00, 8'h00, 2, 32'h0);
		send_byte(8'hAA);
		send_frame(ADDR_REPORT, SUB_PRES, 6, 32'h0);
		send_frame(8'h00, 8'h00, 257, 32'h0);
		send_byte(HDR_BYTE); send_byte(8'hFF); send_byte(8'hFF);
		drain();
	endtask

	// each frame type at its minimum length, plus one below it and an unknown address
	task automatic test_event_kinds();
		send_frame(ADDR_REPORT, SUB_PRES, 10, 32'h0000_0101);
		send_frame(ADDR_REPORT, SUB_PRES, 10, 32'h0000_0200);
		send_frame(ADDR_REPORT, SUB_PRES, 9, 32'h0000_0101);
		send_frame(ADDR_REPORT, SUB_MOVE, 11, 32'h4120_0000);
		send_frame(ADDR_SYS, SUB_ID, 19, 32'h0);
		send_frame(ADDR_SYS, SUB_SW_VER, 22, 32'h0);
		send_frame(ADDR_SYS, SUB_HW_VER, 8, 32'h0);
		send_frame(ADDR_SET, SUB_GEAR, 8, 32'h0000_00FF);
		send_frame(ADDR_SET, SUB_SCENE, 8, 32'h0000_0000);
		send_frame(8'hFF, 8'hFF, 7, 32'h0);
		drain();
	endtask

	// class thresholds on raw float bit patterns
	task automatic test_movement_classes();
		logic [31:0] pats [12];
		int i;
		pats = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h3FFF_FFFF,
			32'h4000_0000, 32'h41F0_0000, 32'h41F0_0001, 32'h4270_0000,
			32'h4270_0001, 32'h7F80_0000, 32'h7FC0_0000, 32'hFF80_0000};
		for (i = 0; i < 12; i++) send_frame(ADDR_REPORT, SUB_MOVE, 11, pats[i]);
		drain();
	endtask

	// scene mode against the configured count, extremes included
	task automatic test_scene_range();
		set_scene_count(8'd255);
		send_frame(ADDR_SET, SUB_SCENE, 8, 32'h0000_00FE);
		send_frame(ADDR_SET, SUB_SCENE, 8, 32'h0000_00FF);
		set_scene_count(8'd1);
		send_frame(ADDR_SET, SUB_SCENE, 8, 32'h0000_0000);
		send_frame(ADDR_SET, SUB_SCENE, 8, 32'h0000_0001);
		set_scene_count(8'd0);
		send_frame(ADDR_SET, SUB_SCENE, 8, 32'h0000_0000);
		drain();
	endtask

	// long frame overruns, stale resync, and clearing after five in a row
	task automatic test_overrun();
		int i;
		calm = 1'b1;
		send_byte(HDR_BYTE); send_byte(8'hFF); send_byte(8'h00);
		for (i = 0; i < 260; i++)
			send_byte((i % 50 == 49) ? HDR_BYTE : ($urandom_range(0, 1) ? 8'h00 : 8'hAA));
		// header bytes only: overruns come close together until the store clears
		for (i = 0; i < 140; i++) send_byte(HDR_BYTE);
		calm = 1'b0;
		drain();
	endtask

	// mostly well-formed frames with random content, some noise and broken frames
	task automatic test_random();
		logic [7:0] pick_a1 [9];
		logic [7:0] pick_a2 [9];
		int sel, size, i, roll;
		pick_a1 = '{ADDR_REPORT, ADDR_REPORT, ADDR_SYS, ADDR_SYS, ADDR_SYS, ADDR_SET,
			ADDR_SET, 8'h00, 8'h00};
		pick_a2 = '{SUB_PRES, SUB_MOVE, SUB_ID, SUB_SW_VER, SUB_HW_VER, SUB_GEAR,
			SUB_SCENE, 8'h00, 8'h00};
		while (bytes_sent < 1050) begin
			roll = $urandom_range(0, 99);
			if (roll == 0) calm = ~calm;
			if (roll < 5) set_scene_count(8'($urandom));
			sel = $urandom_range(0, 8);
			if (sel >= 7) begin
				pick_a1[sel] = 8'($urandom);
				pick_a2[sel] = 8'($urandom);
			end
			roll = $urandom_range(0, 99);
			if (roll < 3) size = $urandom_range(129, 256);
			else if (roll < 5) size = $urandom_range(257, 600);
			else if (roll < 10) size = $urandom_range(1, 6);
			else size = $urandom_range(7, 24);
			send_frame(pick_a1[sel], pick_a2[sel], size, $urandom);
			roll = $urandom_range(0, 99);
			if (roll < 15)
				for (i = $urandom_range(1, 4); i > 0; i--) send_byte(8'($urandom));
			if (bytes_sent > 850 && bytes_sent < 880) drain();
		end
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_framing_limits();
		test_event_kinds();
		test_movement_classes();
		test_scene_range();
		test_overrun();
		test_random();
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/rfr_pkg.sv
rtl/core/rfr_ram.sv
rtl/core/rfr_dp.sv
rtl/core/rfr_ctrl.sv
rtl/core/radar_uart_frame_receiver_unit.sv
sim/radar_uart_frame_receiver_unit_test.sv
